// File: rtl/tsbs_pkg.sv
// Shared types and constants for the timestamp table binary search core.
// No dependencies; imported by all rtl modules.
package tsbs_pkg;

    localparam int CNT_W           = 11;
    localparam int SLOT_W          = 10;
    localparam int SEC_W           = 32;
    localparam int NS_W            = 30;
    localparam int WORD_W          = 32;
    localparam int DEF_TABLE_DEPTH = 1024;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot;
        logic [SEC_W-1:0]  key_seconds;
        logic [NS_W-1:0]   key_nanos;
        logic [WORD_W-1:0] entry_position;
        logic [WORD_W-1:0] entry_length;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] match_index;
        logic [WORD_W-1:0] match_position;
        logic [WORD_W-1:0] match_length;
    } t_out_item;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [NS_W-1:0]   ns;
        logic [WORD_W-1:0] pos;
        logic [WORD_W-1:0] len;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;   // write input entry into table
        logic start;     // latch search key, open window
        logic rd;        // probe table at window midpoint
        logic step;      // narrow window from compare
        logic capture;   // latch search result
        logic hit;       // result is a match (with capture)
        logic out_load;  // move result into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;     // clamped entry count is zero
        logic eq;        // probed entry equals key
        logic last;      // probe sat at window low end
        logic out_free;  // output register can take a result
    } t_dp_stat;

endpackage

// File: rtl/tsbs_dpath.sv
// Datapath: entry table memory, count register, search window, output register.
// Depends on tsbs_pkg.
module tsbs_dpath #(
    parameter int TABLE_DEPTH = tsbs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tsbs_pkg::t_in_item                 i_in_item,
    input  logic                               i_cfg_valid,
    input  logic [tsbs_pkg::CNT_W-1:0]         i_cfg_data,
    input  logic                               i_out_stall,
    input  tsbs_pkg::t_dp_cmd                  i_cmd,
    output tsbs_pkg::t_dp_stat                 o_stat,
    output logic                               o_out_valid,
    output tsbs_pkg::t_out_item                o_out_item
);
    import tsbs_pkg::*;

    localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_entry             r_mem [TABLE_DEPTH];
    t_entry             r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   cnt_clamped;
    logic [SEC_W-1:0]   r_key_sec;
    logic [NS_W-1:0]    r_key_ns;
    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_hi;
    logic [CNT_W-1:0]   r_mid;
    logic [CNT_W-1:0]   mid;
    logic               key_eq;
    logic               key_lt;
    logic               slot_ok;
    t_entry             wr_entry;
    t_out_item          r_res;
    t_out_item          r_out;
    logic               r_out_valid;

    // count register, ready is always high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cfg_valid) begin
            r_cnt <= i_cfg_data;
        end
    end

    always_comb begin
        if (32'(r_cnt) > TABLE_DEPTH) begin
            cnt_clamped = CNT_W'(TABLE_DEPTH);
        end else begin
            cnt_clamped = r_cnt;
        end
    end

    // table memory: one write port, one registered read port
    assign slot_ok  = 32'(i_in_item.slot) < TABLE_DEPTH;
    assign wr_entry = '{sec: i_in_item.key_seconds, ns: i_in_item.key_nanos,
                        pos: i_in_item.entry_position, len: i_in_item.entry_length};
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && slot_ok) begin
            r_mem[AddrW'(i_in_item.slot)] <= wr_entry;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[AddrW'(mid)];
        end
    end

    // search window
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key_sec <= i_in_item.key_seconds;
            r_key_ns  <= i_in_item.key_nanos;
            r_lo      <= '0;
            r_hi      <= cnt_clamped;
        end
        if (i_cmd.rd) begin
            r_mid <= mid;
        end
        if (i_cmd.step) begin
            if (key_lt) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid;
            end
        end
    end

    assign key_eq = {r_key_sec, r_key_ns} == {r_rd.sec, r_rd.ns};
    assign key_lt = {r_key_sec, r_key_ns} <  {r_rd.sec, r_rd.ns};

    // result holding register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_res.found <= i_cmd.hit;
            if (i_cmd.hit) begin
                r_res.match_index    <= SLOT_W'(r_mid);
                r_res.match_position <= r_rd.pos;
                r_res.match_length   <= r_rd.len;
            end else begin
                r_res.match_index    <= '0;
                r_res.match_position <= '0;
                r_res.match_length   <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out;
    assign o_stat.empty    = cnt_clamped == '0;
    assign o_stat.eq       = key_eq;
    assign o_stat.last     = r_mid == r_lo;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // a probe always has a non-empty window
    a_probe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_lo < r_hi))
        else $error("probe issued on empty window");

    // window only narrows when the probe was not at the low end
    a_step_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_mid != r_lo) && !key_eq)
        else $error("window step after final probe");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a stalled result");

endmodule

// File: rtl/tsbs_ctrl.sv
// Controller state machine for the search sequence.
// Depends on tsbs_pkg; drives tsbs_dpath through command/status structs.
module tsbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_op,
    output logic                o_in_stall,
    input  tsbs_pkg::t_dp_stat  i_stat,
    output tsbs_pkg::t_dp_cmd   o_cmd
);
    import tsbs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        if (i_stat.empty) begin
                            o_cmd.capture = 1'b1;
                            n_state       = ST_FINISH;
                        end else begin
                            n_state = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                if (i_stat.eq) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.hit     = 1'b1;
                    n_state       = ST_FINISH;
                end else if (i_stat.last) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/timestamp_table_binary_search_core.sv
// Top level of the timestamp table binary search core.
// Depends on tsbs_pkg, tsbs_ctrl and tsbs_dpath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one transaction
//   per item. A load (operation 0) writes key, position and length into the
//   given slot in the accept cycle and produces no result; slots at or above
//   TABLE_DEPTH are dropped. Loads go back to back, one per cycle, while no search is running.
//   A search (operation 1) runs a binary search over slots 0..count-1
//   (count clamped to TABLE_DEPTH) and returns one result transaction on the
//   output channel (o_out_valid / i_out_stall / o_out_item).
//   Each probe is a registered table read (ST_READ), then the 62-bit key
//   compare and window update (ST_CMP). The input stays stalled from accept
//   until the result moves into the output register; at most 11 probes for
//   1024 entries. An empty table gives a not-found result with no probe.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the entry
//   count; ready is always high. Write it only while the core is idle.
//   Reset (synchronous, active low) clears state machine, output valid and
//   the count. Table contents are not cleared; search only written slots.
//   A stalled result stays in the output register; the core still accepts
//   loads meanwhile and runs a new search, holding its result until the
//   output register frees up.
module timestamp_table_binary_search_core #(
    parameter int TABLE_DEPTH = tsbs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input item channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tsbs_pkg::t_in_item          i_in_item,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tsbs_pkg::t_out_item         o_out_item,
    // entry count write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tsbs_pkg::CNT_W-1:0]  i_cfg_data
);
    import tsbs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // count register accepts a write every cycle
    assign o_cfg_ready = 1'b1;

    tsbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_item.operation),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tsbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
